// ===== rtl/lwesx_pkg.sv =====
package lwesx_pkg;

    localparam int unsigned VAL_W    = 61;
    localparam int unsigned ACT_W    = 4;
    localparam int unsigned LIMB_W   = 2;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned LOGD_W   = 4;
    localparam int unsigned LUSE_W   = 3;
    localparam int unsigned CFG_IX_W = 3;
    localparam int unsigned NCNT_W   = 17;
    localparam int unsigned MOD_REGS = 4;
    localparam int unsigned STEP_W   = 6;

    localparam logic [STEP_W-1:0] RED_LAST = STEP_W'(VAL_W - 1);

    localparam logic [VAL_W-1:0]  MOD_RESET  = {VAL_W{1'b1}};
    localparam logic [LUSE_W-1:0] LUSE_RESET = 3'd2;
    localparam logic [LOGD_W-1:0] LOGD_RESET = 4'd12;

    // configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_MOD0   = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_MOD1   = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_MOD2   = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_MOD3   = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_LIMBS  = 3'd4;
    localparam logic [CFG_IX_W-1:0] CFG_LOGDEG = 3'd5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_EXT_ADD    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_EXT_SUB    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_CONST_ADD  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_CONST_SUB  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_ENTRY_ADD  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ENTRY_SUB  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_NEGATE     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_READ_ENTRY = 4'd8;
    localparam logic [ACT_W-1:0] ACT_READ_CONST = 4'd9;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_VALUE = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_NEG
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHK,
        S_MRD,
        S_MLD,
        S_CRD,
        S_RED,
        S_WR,
        S_CLR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] q;
    } t_red_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] res;
    } t_red_rsp;

endpackage

// ===== rtl/lwesx_in_if.sv =====
interface lwesx_in_if;
    logic                            valid;
    logic                            ready;
    logic [lwesx_pkg::ACT_W-1:0]     action;
    logic [lwesx_pkg::LIMB_W-1:0]    limb;
    logic [lwesx_pkg::POS_W-1:0]     position;
    logic [lwesx_pkg::POS_W-1:0]     extract_index;
    logic [lwesx_pkg::VAL_W-1:0]     value;

    modport source (
        output valid, action, limb, position, extract_index, value,
        input  ready
    );
    modport sink (
        input  valid, action, limb, position, extract_index, value,
        output ready
    );
endinterface

// ===== rtl/lwesx_out_if.sv =====
interface lwesx_out_if;
    logic                          valid;
    logic                          ready;
    logic [lwesx_pkg::VAL_W-1:0]   read_data;
    logic [lwesx_pkg::STAT_W-1:0]  status;

    modport source (
        output valid, read_data, status,
        input  ready
    );
    modport sink (
        input  valid, read_data, status,
        output ready
    );
endinterface

// ===== rtl/lwe_sample_extract_accumulator.sv =====
// LWE accumulator for sample extraction from RLWE ciphertexts.
// Items arrive on i_item (valid/ready) and each gives exactly one result item
// on o_result (read_data, status). Modulus, limb count and log degree are
// written through i_cfg_we / i_cfg_index / i_cfg_data; the user is to write
// them only while the block is idle, which the block itself does not enforce.
// After reset the block sweeps all LIMBS*DEGREE coefficient memory entries to
// zero, one entry per cycle, with i_item.ready low; config writes still land.
// One item at a time: i_item.ready is high only while the sequencer is idle, so
// the next item can be accepted in the cycle after a result is loaded.
// An update of a stored coefficient or of a constant term passes the stored
// value through the shared bit-serial reduction unit; when the modulus is
// nonzero and the value is not below it, the unit produces one remainder bit
// per cycle. Clear writes one memory entry per cycle. Negate walks L limbs of
// N entries, each a read, a reduction and a write, plus the constant term of
// each limb.
// A finished result sits in an output register; a new item is accepted while
// it waits. If the receiver stalls and a second result is ready, the sequencer
// holds in its done state until the output register frees up.
module lwe_sample_extract_accumulator #(
    parameter int unsigned DEGREE = 4096,
    parameter int unsigned LIMBS  = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lwesx_in_if.sink                           i_item,
    lwesx_out_if.source                        o_result,
    input  logic                               i_cfg_we,
    input  logic [lwesx_pkg::CFG_IX_W-1:0]     i_cfg_index,
    input  logic [lwesx_pkg::VAL_W-1:0]        i_cfg_data
);
    localparam int unsigned DEPTH = LIMBS * DEGREE;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned JW    = (DEGREE > 1) ? $clog2(DEGREE) : 1;
    localparam int unsigned LIW   = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int unsigned VW    = lwesx_pkg::VAL_W;
    localparam int unsigned NW    = lwesx_pkg::NCNT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [NW-1:0] DEG_N     = NW'(DEGREE);
    localparam logic [lwesx_pkg::LUSE_W-1:0] MAX_L = lwesx_pkg::LUSE_W'(LIMBS);

    // configuration
    logic [VW-1:0]                    r_mod [lwesx_pkg::MOD_REGS];
    logic [lwesx_pkg::LUSE_W-1:0]     r_lu;
    logic [lwesx_pkg::LOGD_W-1:0]     r_logd;

    // sequencer
    lwesx_pkg::t_state                r_state, n_state;
    logic [lwesx_pkg::ACT_W-1:0]      r_act, n_act;
    logic [lwesx_pkg::LIMB_W-1:0]     r_limb, n_limb;
    logic [lwesx_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [lwesx_pkg::POS_W-1:0]      r_k, n_k;
    logic [VW-1:0]                    r_val, n_val;
    logic [JW-1:0]                    r_j, n_j;
    lwesx_pkg::t_op                   r_op, n_op;
    logic                             r_tgt_const, n_tgt_const;
    logic                             r_clr_item, n_clr_item;
    logic [AW-1:0]                    r_clr, n_clr;
    logic [VW-1:0]                    r_rd, n_rd;
    logic [lwesx_pkg::STAT_W-1:0]     r_st, n_st;

    // output register
    logic                             r_ov;
    logic [VW-1:0]                    r_ord;
    logic [lwesx_pkg::STAT_W-1:0]     r_ost;
    logic                             out_load;

    // constant terms
    logic [VW-1:0]                    r_const [LIMBS];
    logic                             const_we;
    logic                             const_clr;

    // memory and reduction unit
    logic                             mem_we;
    logic                             mem_re;
    logic [AW-1:0]                    mem_waddr;
    logic [AW-1:0]                    ent_addr;
    logic [VW-1:0]                    mem_wdata;
    logic [VW-1:0]                    mem_rdata;
    lwesx_pkg::t_red_req              red_req;
    lwesx_pkg::t_red_rsp              red_rsp;

    // decode helpers
    logic [NW-1:0]                    n_full;
    logic [NW-1:0]                    cur_n;
    logic [lwesx_pkg::LUSE_W-1:0]     cur_l;
    logic [VW-1:0]                    q_cur;
    logic [VW-1:0]                    const_cur;
    logic [LIW-1:0]                   cidx;
    logic                             limb_bad;
    logic                             pos_bad;
    logic                             k_bad;
    logic                             val_bad;
    logic [NW-1:0]                    dst;
    logic                             dst_wrap;
    logic                             last_j;
    logic                             last_l;

    // update arithmetic
    logic [VW-1:0]                    red_r;
    logic [VW:0]                      sum;
    logic [VW:0]                      sum_m;
    logic [VW:0]                      dif;
    logic [VW-1:0]                    neg;
    logic [VW-1:0]                    upd;

    assign n_full    = NW'(1) << r_logd;
    assign cur_n     = (n_full > DEG_N) ? DEG_N : n_full;
    assign cur_l     = (r_lu > MAX_L) ? MAX_L : r_lu;
    assign q_cur     = r_mod[r_limb];
    assign cidx      = r_limb[LIW-1:0];
    assign const_cur = r_const[cidx];
    assign limb_bad  = {1'b0, r_limb} >= cur_l;
    assign pos_bad   = NW'(r_pos) >= cur_n;
    assign k_bad     = NW'(r_k) >= cur_n;
    assign val_bad   = r_val >= q_cur;
    assign dst_wrap  = r_pos > r_k;
    assign dst       = dst_wrap ? (cur_n + NW'(r_k) - NW'(r_pos)) : NW'(r_k - r_pos);
    assign last_j    = NW'(r_j) == (cur_n - 1'b1);
    assign last_l    = ({1'b0, r_limb} + 1'b1) == cur_l;
    assign ent_addr  = AW'(r_limb) * AW'(DEGREE) + AW'(r_j);

    assign red_r = red_rsp.res;
    assign sum   = {1'b0, red_r} + {1'b0, r_val};
    assign sum_m = (sum >= {1'b0, q_cur}) ? (sum - {1'b0, q_cur}) : sum;
    assign dif   = (red_r >= r_val) ? ({1'b0, red_r} - {1'b0, r_val})
                                    : ({1'b0, red_r} + {1'b0, q_cur} - {1'b0, r_val});
    assign neg   = (q_cur == '0) ? red_r : ((red_r == '0) ? '0 : (q_cur - red_r));

    always_comb begin
        case (r_op)
            lwesx_pkg::OP_ADD: upd = sum_m[VW-1:0];
            lwesx_pkg::OP_SUB: upd = dif[VW-1:0];
            lwesx_pkg::OP_NEG: upd = neg;
            default:           upd = neg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lwesx_pkg::MOD_REGS; i++) begin
                r_mod[i] <= lwesx_pkg::MOD_RESET;
            end
            r_lu   <= lwesx_pkg::LUSE_RESET;
            r_logd <= lwesx_pkg::LOGD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lwesx_pkg::CFG_MOD0:   r_mod[0] <= i_cfg_data;
                lwesx_pkg::CFG_MOD1:   r_mod[1] <= i_cfg_data;
                lwesx_pkg::CFG_MOD2:   r_mod[2] <= i_cfg_data;
                lwesx_pkg::CFG_MOD3:   r_mod[3] <= i_cfg_data;
                lwesx_pkg::CFG_LIMBS:  r_lu     <= i_cfg_data[lwesx_pkg::LUSE_W-1:0];
                lwesx_pkg::CFG_LOGDEG: r_logd   <= i_cfg_data[lwesx_pkg::LOGD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_limb      = r_limb;
        n_pos       = r_pos;
        n_k         = r_k;
        n_val       = r_val;
        n_j         = r_j;
        n_op        = r_op;
        n_tgt_const = r_tgt_const;
        n_clr_item  = r_clr_item;
        n_clr       = r_clr;
        n_rd        = r_rd;
        n_st        = r_st;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = ent_addr;
        mem_wdata   = upd;
        const_we    = 1'b0;
        const_clr   = 1'b0;
        out_load    = 1'b0;
        red_req     = '{start: 1'b0, a: const_cur, q: q_cur};

        case (r_state)
            lwesx_pkg::S_INIT, lwesx_pkg::S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = r_clr_item ? lwesx_pkg::S_DONE : lwesx_pkg::S_IDLE;
                end
            end
            lwesx_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    n_act   = i_item.action;
                    // negate walks the limbs from zero
                    n_limb  = (i_item.action == lwesx_pkg::ACT_NEGATE) ? '0 : i_item.limb;
                    n_pos   = i_item.position;
                    n_k     = i_item.extract_index;
                    n_val   = i_item.value;
                    n_state = lwesx_pkg::S_CHK;
                end
            end
            lwesx_pkg::S_CHK: begin
                n_rd        = '0;
                n_st        = lwesx_pkg::STAT_OK;
                n_tgt_const = 1'b0;
                n_state     = lwesx_pkg::S_DONE;
                if (r_act == lwesx_pkg::ACT_CLEAR) begin
                    const_clr  = 1'b1;
                    n_clr      = '0;
                    n_clr_item = 1'b1;
                    n_state    = lwesx_pkg::S_CLR;
                end else if (r_act == lwesx_pkg::ACT_NEGATE) begin
                    n_op = lwesx_pkg::OP_NEG;
                    n_j  = '0;
                    if (cur_l != '0) begin
                        n_state = lwesx_pkg::S_MRD;
                    end
                end else if (r_act > lwesx_pkg::ACT_READ_CONST || limb_bad) begin
                    n_st = lwesx_pkg::STAT_RANGE;
                end else begin
                    case (r_act)
                        lwesx_pkg::ACT_EXT_ADD, lwesx_pkg::ACT_EXT_SUB: begin
                            if (pos_bad || k_bad) begin
                                n_st = lwesx_pkg::STAT_RANGE;
                            end else if (val_bad) begin
                                n_st = lwesx_pkg::STAT_VALUE;
                            end else begin
                                n_j  = dst[JW-1:0];
                                // wrapped positions take the opposite sign
                                n_op = ((r_act == lwesx_pkg::ACT_EXT_SUB) ^ dst_wrap)
                                       ? lwesx_pkg::OP_SUB : lwesx_pkg::OP_ADD;
                                n_state = lwesx_pkg::S_MRD;
                            end
                        end
                        lwesx_pkg::ACT_CONST_ADD, lwesx_pkg::ACT_CONST_SUB: begin
                            if (val_bad) begin
                                n_st = lwesx_pkg::STAT_VALUE;
                            end else begin
                                n_op = (r_act == lwesx_pkg::ACT_CONST_SUB)
                                       ? lwesx_pkg::OP_SUB : lwesx_pkg::OP_ADD;
                                n_tgt_const   = 1'b1;
                                red_req.start = 1'b1;
                                n_state       = lwesx_pkg::S_RED;
                            end
                        end
                        lwesx_pkg::ACT_ENTRY_ADD, lwesx_pkg::ACT_ENTRY_SUB: begin
                            if (pos_bad) begin
                                n_st = lwesx_pkg::STAT_RANGE;
                            end else if (val_bad) begin
                                n_st = lwesx_pkg::STAT_VALUE;
                            end else begin
                                n_j  = r_pos[JW-1:0];
                                n_op = (r_act == lwesx_pkg::ACT_ENTRY_SUB)
                                       ? lwesx_pkg::OP_SUB : lwesx_pkg::OP_ADD;
                                n_state = lwesx_pkg::S_MRD;
                            end
                        end
                        lwesx_pkg::ACT_READ_ENTRY: begin
                            if (pos_bad) begin
                                n_st = lwesx_pkg::STAT_RANGE;
                            end else begin
                                n_j     = r_pos[JW-1:0];
                                n_state = lwesx_pkg::S_MRD;
                            end
                        end
                        default: begin
                            n_state = lwesx_pkg::S_CRD;
                        end
                    endcase
                end
            end
            lwesx_pkg::S_MRD: begin
                mem_re  = 1'b1;
                n_state = lwesx_pkg::S_MLD;
            end
            lwesx_pkg::S_MLD: begin
                if (r_act == lwesx_pkg::ACT_READ_ENTRY) begin
                    n_rd    = mem_rdata;
                    n_state = lwesx_pkg::S_DONE;
                end else begin
                    red_req.start = 1'b1;
                    red_req.a     = mem_rdata;
                    n_state       = lwesx_pkg::S_RED;
                end
            end
            lwesx_pkg::S_CRD: begin
                n_rd    = const_cur;
                n_state = lwesx_pkg::S_DONE;
            end
            lwesx_pkg::S_RED: begin
                if (red_rsp.done) begin
                    n_state = lwesx_pkg::S_WR;
                end
            end
            lwesx_pkg::S_WR: begin
                mem_we   = !r_tgt_const;
                const_we = r_tgt_const;
                n_state  = lwesx_pkg::S_DONE;
                if (r_act == lwesx_pkg::ACT_NEGATE) begin
                    if (!r_tgt_const) begin
                        if (last_j) begin
                            // entries of this limb done: negate its constant term
                            n_tgt_const   = 1'b1;
                            red_req.start = 1'b1;
                            n_state       = lwesx_pkg::S_RED;
                        end else begin
                            n_j     = r_j + 1'b1;
                            n_state = lwesx_pkg::S_MRD;
                        end
                    end else if (!last_l) begin
                        n_limb      = r_limb + 1'b1;
                        n_j         = '0;
                        n_tgt_const = 1'b0;
                        n_state     = lwesx_pkg::S_MRD;
                    end
                end
            end
            lwesx_pkg::S_DONE: begin
                if (!r_ov || o_result.ready) begin
                    out_load   = 1'b1;
                    n_clr_item = 1'b0;
                    n_state    = lwesx_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lwesx_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lwesx_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_clr_item  <= 1'b0;
            r_tgt_const <= 1'b0;
        end else begin
            r_clr       <= n_clr;
            r_clr_item  <= n_clr_item;
            r_tgt_const <= n_tgt_const;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_limb <= n_limb;
        r_pos  <= n_pos;
        r_k    <= n_k;
        r_val  <= n_val;
        r_j    <= n_j;
        r_op   <= n_op;
        r_rd   <= n_rd;
        r_st   <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || const_clr) begin
            for (int i = 0; i < LIMBS; i++) begin
                r_const[i] <= '0;
            end
        end else if (const_we) begin
            r_const[cidx] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ord <= r_rd;
            r_ost <= r_st;
        end
    end

    assign i_item.ready       = (r_state == lwesx_pkg::S_IDLE);
    assign o_result.valid     = r_ov;
    assign o_result.read_data = r_ord;
    assign o_result.status    = r_ost;

    lwesx_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (ent_addr),
        .o_rdata (mem_rdata)
    );

    lwesx_modred u_modred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (red_req),
        .o_rsp   (red_rsp)
    );
endmodule

// ===== rtl/lwesx_modred.sv =====
module lwesx_modred (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lwesx_pkg::t_red_req i_req,
    output lwesx_pkg::t_red_rsp o_rsp
);
    logic                               r_busy;
    logic                               r_done;
    logic [lwesx_pkg::STEP_W-1:0]       r_cnt;
    logic [lwesx_pkg::VAL_W-1:0]        r_rem;
    logic [lwesx_pkg::VAL_W-1:0]        r_a;
    logic [lwesx_pkg::VAL_W-1:0]        r_q;
    logic [lwesx_pkg::VAL_W:0]          rem_sh;
    logic [lwesx_pkg::VAL_W:0]          rem_sub;
    logic [lwesx_pkg::VAL_W-1:0]        rem_nx;
    logic                               trivial;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh  = {r_rem, r_a[lwesx_pkg::VAL_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_q};
    assign rem_nx  = (rem_sh >= {1'b0, r_q}) ? rem_sub[lwesx_pkg::VAL_W-1:0]
                                             : rem_sh[lwesx_pkg::VAL_W-1:0];
    assign trivial = (i_req.q == '0) || (i_req.a < i_req.q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= !trivial;
                r_done <= trivial;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lwesx_pkg::RED_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.q;
            r_a   <= i_req.a;
            // already reduced (or modulus zero): pass through unchanged
            r_rem <= trivial ? i_req.a : '0;
        end else if (r_busy) begin
            r_a   <= {r_a[lwesx_pkg::VAL_W-2:0], 1'b0};
            r_rem <= rem_nx;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_rem;
endmodule

// ===== rtl/lwesx_store.sv =====
module lwesx_store #(
    parameter int unsigned DEPTH  = 16384,
    parameter int unsigned ADDR_W = 14
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [ADDR_W-1:0]             i_waddr,
    input  logic [lwesx_pkg::VAL_W-1:0]   i_wdata,
    input  logic                          i_re,
    input  logic [ADDR_W-1:0]             i_raddr,
    output logic [lwesx_pkg::VAL_W-1:0]   o_rdata
);
    logic [lwesx_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [lwesx_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== tb/lwe_accum_monitor.sv =====
`timescale 1ns / 100ps

module lwe_accum_monitor #(
    parameter int unsigned DEGREE = 4096,
    parameter int unsigned LIMBS  = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lwesx_in_if                            i_item,
    lwesx_out_if                           i_result,
    input  logic                           i_cfg_we,
    input  logic [lwesx_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [lwesx_pkg::VAL_W-1:0]    i_cfg_data,
    output int                             o_failures,
    output int                             o_owed,
    output int                             o_checked
);

    typedef struct packed {
        logic [lwesx_pkg::VAL_W-1:0]  read_data;
        logic [lwesx_pkg::STAT_W-1:0] status;
    } t_reply;

    logic [lwesx_pkg::VAL_W-1:0]  coeffs [LIMBS*DEGREE];
    logic [lwesx_pkg::VAL_W-1:0]  consts [LIMBS];
    logic [lwesx_pkg::VAL_W-1:0]  moduli [lwesx_pkg::MOD_REGS];
    logic [lwesx_pkg::LUSE_W-1:0] limbs_reg;
    logic [lwesx_pkg::LOGD_W-1:0] logdeg_reg;
    t_reply                       due_replies [$];
    int                           fail_total;
    int                           checked_total;

    function automatic logic [63:0] fold(input logic [63:0] x, input logic [63:0] q);
        return (q == 64'd0) ? x : x % q;
    endfunction

    function automatic logic [lwesx_pkg::VAL_W-1:0] add_q(input logic [63:0] a,
                                                          input logic [63:0] b,
                                                          input logic [63:0] q);
        logic [63:0] s;
        s = fold(a, q) + b;
        if (s >= q) s = s - q;
        return s[lwesx_pkg::VAL_W-1:0];
    endfunction

    function automatic logic [lwesx_pkg::VAL_W-1:0] sub_q(input logic [63:0] a,
                                                          input logic [63:0] b,
                                                          input logic [63:0] q);
        logic [63:0] r;
        r = fold(a, q);
        r = (r >= b) ? r - b : r + q - b;
        return r[lwesx_pkg::VAL_W-1:0];
    endfunction

    function automatic logic [lwesx_pkg::VAL_W-1:0] neg_q(input logic [63:0] a,
                                                          input logic [63:0] q);
        logic [63:0] r;
        if (q == 64'd0) return a[lwesx_pkg::VAL_W-1:0];
        r = a % q;
        r = (r == 64'd0) ? 64'd0 : q - r;
        return r[lwesx_pkg::VAL_W-1:0];
    endfunction

    function automatic int unsigned live_degree();
        int unsigned n;
        n = 32'd1 << logdeg_reg;
        return (n > DEGREE) ? DEGREE : n;
    endfunction

    function automatic int unsigned live_limbs();
        return (limbs_reg > LIMBS) ? LIMBS : 32'(limbs_reg);
    endfunction

    task automatic wipe_all();
        for (int j = 0; j < LIMBS * DEGREE; j++) coeffs[j] = '0;
        for (int l = 0; l < LIMBS; l++) consts[l] = '0;
    endtask

    task automatic predict_reply(input logic [lwesx_pkg::ACT_W-1:0] act,
                                 input logic [lwesx_pkg::LIMB_W-1:0] lb,
                                 input logic [lwesx_pkg::POS_W-1:0] pos,
                                 input logic [lwesx_pkg::POS_W-1:0] k,
                                 input logic [lwesx_pkg::VAL_W-1:0] val,
                                 output t_reply rep);
        int unsigned n;
        int unsigned nl;
        int unsigned slot;
        logic [63:0] q;
        logic [63:0] v;
        bit          plus;
        rep = '0;
        n = live_degree();
        nl = live_limbs();
        q = 64'(moduli[lb]);
        v = 64'(val);
        if (act == lwesx_pkg::ACT_CLEAR) begin
            wipe_all();
        end else if (act == lwesx_pkg::ACT_NEGATE) begin
            for (int l = 0; l < nl; l++) begin
                for (int j = 0; j < n; j++)
                    coeffs[l*DEGREE + j] = neg_q(64'(coeffs[l*DEGREE + j]), 64'(moduli[l]));
                consts[l] = neg_q(64'(consts[l]), 64'(moduli[l]));
            end
        end else if (act > lwesx_pkg::ACT_READ_CONST || lb >= nl) begin
            rep.status = lwesx_pkg::STAT_RANGE;
        end else if (act == lwesx_pkg::ACT_EXT_ADD || act == lwesx_pkg::ACT_EXT_SUB) begin
            if (pos >= n || k >= n) begin
                rep.status = lwesx_pkg::STAT_RANGE;
            end else if (v >= q) begin
                rep.status = lwesx_pkg::STAT_VALUE;
            end else begin
                // a source position past k wraps around and flips the sign
                plus = (pos <= k);
                slot = plus ? 32'(k) - 32'(pos) : n + 32'(k) - 32'(pos);
                if (act == lwesx_pkg::ACT_EXT_SUB) plus = !plus;
                slot = slot + lb * DEGREE;
                coeffs[slot] = plus ? add_q(64'(coeffs[slot]), v, q)
                                    : sub_q(64'(coeffs[slot]), v, q);
            end
        end else if (act == lwesx_pkg::ACT_CONST_ADD || act == lwesx_pkg::ACT_CONST_SUB) begin
            if (v >= q) begin
                rep.status = lwesx_pkg::STAT_VALUE;
            end else begin
                consts[lb] = (act == lwesx_pkg::ACT_CONST_ADD)
                             ? add_q(64'(consts[lb]), v, q)
                             : sub_q(64'(consts[lb]), v, q);
            end
        end else if (act == lwesx_pkg::ACT_ENTRY_ADD || act == lwesx_pkg::ACT_ENTRY_SUB) begin
            if (pos >= n) begin
                rep.status = lwesx_pkg::STAT_RANGE;
            end else if (v >= q) begin
                rep.status = lwesx_pkg::STAT_VALUE;
            end else begin
                slot = lb * DEGREE + 32'(pos);
                coeffs[slot] = (act == lwesx_pkg::ACT_ENTRY_ADD)
                               ? add_q(64'(coeffs[slot]), v, q)
                               : sub_q(64'(coeffs[slot]), v, q);
            end
        end else if (act == lwesx_pkg::ACT_READ_ENTRY) begin
            if (pos >= n) rep.status = lwesx_pkg::STAT_RANGE;
            else rep.read_data = coeffs[lb*DEGREE + 32'(pos)];
        end else begin
            rep.read_data = consts[lb];
        end
    endtask

    task automatic note_failure(input string what);
        fail_total++;
        if (fail_total <= 10) $display("%s", what);
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        t_reply seen;
        if (!i_rst_n) begin
            wipe_all();
            for (int r = 0; r < lwesx_pkg::MOD_REGS; r++) moduli[r] = lwesx_pkg::MOD_RESET;
            limbs_reg = lwesx_pkg::LUSE_RESET;
            logdeg_reg = lwesx_pkg::LOGD_RESET;
            due_replies.delete();
            fail_total = 0;
            checked_total = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == lwesx_pkg::CFG_LIMBS)
                    limbs_reg = i_cfg_data[lwesx_pkg::LUSE_W-1:0];
                else if (i_cfg_index == lwesx_pkg::CFG_LOGDEG)
                    logdeg_reg = i_cfg_data[lwesx_pkg::LOGD_W-1:0];
                else if (i_cfg_index < lwesx_pkg::CFG_LIMBS)
                    moduli[i_cfg_index[1:0]] = i_cfg_data;
            end
            if (i_item.valid && i_item.ready) begin
                predict_reply(i_item.action, i_item.limb, i_item.position,
                              i_item.extract_index, i_item.value, want);
                due_replies.push_back(want);
            end
            if (i_result.valid && i_result.ready) begin
                seen.read_data = i_result.read_data;
                seen.status = i_result.status;
                checked_total++;
                if (due_replies.size() == 0) begin
                    note_failure($sformatf(
                        "result %0d arrived with nothing outstanding: data %h status %0d",
                        checked_total, seen.read_data, seen.status));
                end else begin
                    want = due_replies.pop_front();
                    if (seen.read_data !== want.read_data)
                        note_failure($sformatf(
                            "read_data mismatch on result %0d: expected %h, got %h",
                            checked_total, want.read_data, seen.read_data));
                    if (seen.status !== want.status)
                        note_failure($sformatf(
                            "status mismatch on result %0d: expected %0d, got %0d",
                            checked_total, want.status, seen.status));
                end
            end
        end
        o_owed <= due_replies.size();
        o_failures <= fail_total;
        o_checked <= checked_total;
    end

endmodule

// ===== tb/lwe_sample_extract_accumulator_test.sv =====
`timescale 1ns / 100ps

module lwe_sample_extract_accumulator_test;

    localparam int unsigned DEGREE    = 4096;
    localparam int unsigned LIMBS     = 4;
    localparam int          LONG_HOLD = 400;
    localparam int          LIMIT_NS  = 40_000_000;

    typedef struct packed {
        logic [lwesx_pkg::ACT_W-1:0]  action;
        logic [lwesx_pkg::LIMB_W-1:0] limb;
        logic [lwesx_pkg::POS_W-1:0]  position;
        logic [lwesx_pkg::POS_W-1:0]  extract_index;
        logic [lwesx_pkg::VAL_W-1:0]  value;
    } t_lwe_item;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lwesx_pkg::CFG_IX_W-1:0] i_cfg_index;
    logic [lwesx_pkg::VAL_W-1:0]    i_cfg_data;
    int                             failures;
    int                             owed;
    int                             checked;

    logic [lwesx_pkg::VAL_W-1:0]    mod_now [lwesx_pkg::MOD_REGS];
    logic [lwesx_pkg::LUSE_W-1:0]   luse_now;
    logic [lwesx_pkg::LOGD_W-1:0]   logd_now;
    bit                             send_gaps;
    bit                             recv_gaps;
    bit                             long_hold_req;
    int                             items_sent;
    int                             clears_sent;
    int                             negates_sent;
    int                             settings_used;

    lwesx_in_if  item_ch ();
    lwesx_out_if result_ch ();

    lwe_sample_extract_accumulator #(.DEGREE(DEGREE), .LIMBS(LIMBS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lwe_accum_monitor #(.DEGREE(DEGREE), .LIMBS(LIMBS)) accum_mon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .i_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_owed      (owed),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #LIMIT_NS;
        $display("simulation failed");
        $finish;
    end

    function automatic t_lwe_item pack_item(input logic [lwesx_pkg::ACT_W-1:0] act,
                                            input logic [lwesx_pkg::LIMB_W-1:0] lb,
                                            input logic [lwesx_pkg::POS_W-1:0] pos,
                                            input logic [lwesx_pkg::POS_W-1:0] k,
                                            input logic [lwesx_pkg::VAL_W-1:0] val);
        t_lwe_item it;
        it.action = act;
        it.limb = lb;
        it.position = pos;
        it.extract_index = k;
        it.value = val;
        return it;
    endfunction

    function automatic t_lwe_item make_item();
        t_lwe_item   it;
        int unsigned n;
        int unsigned nl;
        int unsigned pick;
        logic [63:0] q;
        n = 32'd1 << logd_now;
        if (n > DEGREE) n = DEGREE;
        nl = (luse_now > LIMBS) ? LIMBS : 32'(luse_now);
        it.limb = lwesx_pkg::LIMB_W'($urandom);
        it.position = lwesx_pkg::POS_W'($urandom);
        it.extract_index = lwesx_pkg::POS_W'($urandom);
        it.value = lwesx_pkg::VAL_W'({$urandom, $urandom});
        pick = $urandom_range(0, 999);
        if (pick < 850) begin
            // well-formed: in-range indexes, value below the limb modulus
            if (nl != 0) it.limb = lwesx_pkg::LIMB_W'($urandom_range(0, nl - 1));
            it.position = lwesx_pkg::POS_W'($urandom_range(0, n - 1));
            it.extract_index = lwesx_pkg::POS_W'($urandom_range(0, n - 1));
            q = 64'(mod_now[it.limb]);
            if (q < 64'd2) it.value = '0;
            else begin
                pick = $urandom_range(0, 9);
                if (pick == 0) it.value = '0;
                else if (pick == 1) it.value = lwesx_pkg::VAL_W'(q - 64'd1);
                else it.value = lwesx_pkg::VAL_W'({$urandom, $urandom} % q);
            end
            pick = $urandom_range(0, 999);
            if (pick < 190) it.action = lwesx_pkg::ACT_EXT_ADD;
            else if (pick < 380) it.action = lwesx_pkg::ACT_EXT_SUB;
            else if (pick < 430) it.action = lwesx_pkg::ACT_CONST_ADD;
            else if (pick < 480) it.action = lwesx_pkg::ACT_CONST_SUB;
            else if (pick < 560) it.action = lwesx_pkg::ACT_ENTRY_ADD;
            else if (pick < 640) it.action = lwesx_pkg::ACT_ENTRY_SUB;
            else if (pick < 800) it.action = lwesx_pkg::ACT_READ_ENTRY;
            else if (pick < 960) it.action = lwesx_pkg::ACT_READ_CONST;
            else if (pick < 995)
                it.action = (n * nl <= 64) ? lwesx_pkg::ACT_NEGATE : lwesx_pkg::ACT_READ_ENTRY;
            else it.action = lwesx_pkg::ACT_CLEAR;
        end else begin
            // noise: any action code but clear and negate, wild indexes, values at or past the modulus
            it.action = lwesx_pkg::ACT_W'($urandom_range(0, 15));
            if (it.action == lwesx_pkg::ACT_CLEAR || it.action == lwesx_pkg::ACT_NEGATE)
                it.action = lwesx_pkg::ACT_READ_ENTRY;
            if ($urandom_range(0, 1) == 0)
                it.value = mod_now[it.limb] + lwesx_pkg::VAL_W'($urandom_range(0, 3));
        end
        return it;
    endfunction

    task automatic push_item(input t_lwe_item it);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= it.action;
        item_ch.limb <= it.limb;
        item_ch.position <= it.position;
        item_ch.extract_index <= it.extract_index;
        item_ch.value <= it.value;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
        if (it.action == lwesx_pkg::ACT_CLEAR) clears_sent++;
        if (it.action == lwesx_pkg::ACT_NEGATE) negates_sent++;
    endtask

    // drop valid and hold until every outstanding result has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [lwesx_pkg::CFG_IX_W-1:0] ix,
                           input logic [lwesx_pkg::VAL_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= ix;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input bit junk_high);
        logic [lwesx_pkg::VAL_W-1:0] pad;
        pad = junk_high ? lwesx_pkg::VAL_W'({$urandom, $urandom}) : '0;
        put_reg(lwesx_pkg::CFG_MOD0, mod_now[0]);
        put_reg(lwesx_pkg::CFG_MOD1, mod_now[1]);
        put_reg(lwesx_pkg::CFG_MOD2, mod_now[2]);
        put_reg(lwesx_pkg::CFG_MOD3, mod_now[3]);
        put_reg(lwesx_pkg::CFG_LIMBS, {pad[lwesx_pkg::VAL_W-1:lwesx_pkg::LUSE_W], luse_now});
        put_reg(lwesx_pkg::CFG_LOGDEG, {pad[lwesx_pkg::VAL_W-1:lwesx_pkg::LOGD_W], logd_now});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic pick_settings();
        int unsigned sel;
        for (int r = 0; r < lwesx_pkg::MOD_REGS; r++) begin
            sel = $urandom_range(0, 9);
            if (sel < 3) mod_now[r] = lwesx_pkg::MOD_RESET;
            else if (sel < 5) mod_now[r] = lwesx_pkg::VAL_W'($urandom_range(2, 17));
            else if (sel == 5) mod_now[r] = lwesx_pkg::VAL_W'(2);
            else begin
                mod_now[r] = lwesx_pkg::VAL_W'({$urandom, $urandom});
                if (mod_now[r] < lwesx_pkg::VAL_W'(2)) mod_now[r] = lwesx_pkg::VAL_W'(2);
            end
        end
        luse_now = lwesx_pkg::LUSE_W'($urandom_range(1, 4));
        sel = $urandom_range(0, 9);
        if (sel < 7) logd_now = lwesx_pkg::LOGD_W'($urandom_range(1, 4));
        else if (sel < 9) logd_now = lwesx_pkg::LOGD_W'($urandom_range(5, 7));
        else logd_now = lwesx_pkg::LOGD_RESET;
    endtask

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++) push_item(make_item());
        drain();
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                hold_left = LONG_HOLD;
            end else if (recv_gaps && $urandom_range(0, 6) == 0) begin
                result_ch.ready <= 1'b0;
                hold_left = $urandom_range(1, 18) - 1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [lwesx_pkg::VAL_W-1:0] top_ok;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= lwesx_pkg::CFG_MOD0;
        i_cfg_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.action <= lwesx_pkg::ACT_CLEAR;
        item_ch.limb <= '0;
        item_ch.position <= '0;
        item_ch.extract_index <= '0;
        item_ch.value <= '0;
        for (int r = 0; r < lwesx_pkg::MOD_REGS; r++) mod_now[r] = lwesx_pkg::MOD_RESET;
        luse_now = lwesx_pkg::LUSE_RESET;
        logd_now = lwesx_pkg::LOGD_RESET;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        long_hold_req = 1'b0;
        items_sent = 0;
        clears_sent = 0;
        negates_sent = 0;
        settings_used = 0;
        top_ok = lwesx_pkg::MOD_RESET - lwesx_pkg::VAL_W'(1);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // largest moduli, two limbs, full degree; lands while the store is swept
        load_settings(1'b0);
        push_item(pack_item(lwesx_pkg::ACT_EXT_ADD, 2'd0, 12'd0, 12'd0, top_ok));
        push_item(pack_item(lwesx_pkg::ACT_EXT_ADD, 2'd1, 12'd4095, 12'd0, 61'd5));
        push_item(pack_item(lwesx_pkg::ACT_EXT_SUB, 2'd0, 12'd4095, 12'd4095, 61'd1));
        push_item(pack_item(lwesx_pkg::ACT_EXT_SUB, 2'd1, 12'd1, 12'd0, 61'd7));
        push_item(pack_item(lwesx_pkg::ACT_EXT_ADD, 2'd0, 12'd0, 12'd4095,
                            lwesx_pkg::MOD_RESET));
        // bad limb wins over a bad value
        push_item(pack_item(lwesx_pkg::ACT_EXT_ADD, 2'd2, 12'd4095, 12'd4095,
                            lwesx_pkg::MOD_RESET));
        push_item(pack_item(lwesx_pkg::ACT_CONST_ADD, 2'd0, 12'd0, 12'd0, top_ok));
        push_item(pack_item(lwesx_pkg::ACT_CONST_SUB, 2'd1, 12'd0, 12'd0, 61'd3));
        push_item(pack_item(lwesx_pkg::ACT_ENTRY_ADD, 2'd1, 12'd4095, 12'd0, 61'd12345));
        push_item(pack_item(lwesx_pkg::ACT_ENTRY_SUB, 2'd0, 12'd0, 12'd0, top_ok));
        push_item(pack_item(lwesx_pkg::ACT_READ_ENTRY, 2'd0, 12'd0, 12'd0, '0));
        push_item(pack_item(lwesx_pkg::ACT_READ_ENTRY, 2'd1, 12'd4095, 12'd0, '0));
        push_item(pack_item(lwesx_pkg::ACT_READ_CONST, 2'd0, 12'd0, 12'd0, '0));
        push_item(pack_item(lwesx_pkg::ACT_READ_CONST, 2'd1, 12'd0, 12'd0, '0));
        push_item(pack_item(lwesx_pkg::ACT_READ_CONST, 2'd3, 12'd0, 12'd0, '0));
        push_item(pack_item(lwesx_pkg::ACT_NEGATE, 2'd3, 12'd4095, 12'd4095,
                            lwesx_pkg::MOD_RESET));
        push_item(pack_item(lwesx_pkg::ACT_READ_ENTRY, 2'd1, 12'd1, 12'd0, '0));
        push_item(pack_item(lwesx_pkg::ACT_READ_CONST, 2'd0, 12'd0, 12'd0, '0));
        push_item(pack_item(lwesx_pkg::ACT_W'(15), 2'd0, 12'd0, 12'd0,
                            lwesx_pkg::MOD_RESET));
        push_item(pack_item(lwesx_pkg::ACT_W'(10), 2'd1, 12'd7, 12'd9, 61'd1));
        push_item(pack_item(lwesx_pkg::ACT_CLEAR, 2'd3, 12'd4095, 12'd4095,
                            lwesx_pkg::MOD_RESET));
        push_item(pack_item(lwesx_pkg::ACT_READ_CONST, 2'd1, 12'd0, 12'd0, '0));
        drain();

        // moduli zero and one, limb count above the maximum, degree one
        mod_now[0] = '0;
        mod_now[1] = lwesx_pkg::VAL_W'(1);
        mod_now[2] = lwesx_pkg::VAL_W'(2);
        mod_now[3] = lwesx_pkg::MOD_RESET;
        luse_now = lwesx_pkg::LUSE_W'(7);
        logd_now = '0;
        load_settings(1'b1);
        run_phase(30);

        // no limb in range, degree capped
        luse_now = '0;
        logd_now = lwesx_pkg::LOGD_W'(15);
        load_settings(1'b1);
        run_phase(12);

        // hold the result side off while items keep coming, so the input stalls
        pick_settings();
        load_settings(1'b0);
        long_hold_req = 1'b1;
        run_phase(40);

        while (items_sent < 620) begin
            pick_settings();
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            load_settings(1'($urandom_range(0, 1)));
            run_phase($urandom_range(50, 100));
        end

        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        pick_settings();
        load_settings(1'b0);
        run_phase(80);
        repeat (80) @(posedge i_clk);

        $display("covered %0d items over %0d register settings, %0d clears and %0d negates",
                 items_sent, settings_used, clears_sent, negates_sent);
        $display("%0d result items compared with the predicted accumulator", checked);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
